>>> rtl/core/msb_first_bit_packer_macros.svh
// Assertion macros for the MSB-first bit packer.
// Files that assert include this header; defining SYNTH turns the macros into nothing.
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

`ifndef SYNTH
`define MFBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mfbp assertion failed");
`define MFBP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mfbp assertion failed");
`else
`define MFBP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MFBP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/mfbp_pkg.sv
// Shared types and constants of the MSB-first bit packer.
// Used by mfbp_align and msb_first_bit_packer; depends on nothing.
package mfbp_pkg;

    localparam int FIELD_MAX_W = 64;
    localparam int WIDTH_W     = 7;
    localparam int BITS_W      = 19;
    localparam int CAP_W       = 16;
    localparam int WORD_W      = 72;
    localparam int CNT_W       = 4;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  nbytes;
        logic [CNT_W-1:0]  nres;
    } align_t;

endpackage

>>> rtl/core/mfbp_align.sv
// Shift unit of the MSB-first bit packer: places a field behind the partial byte.
// Depends on mfbp_pkg for widths and the align_t result type.
module mfbp_align
(
    input  logic [mfbp_pkg::FIELD_MAX_W-1:0] value,
    input  logic [mfbp_pkg::WIDTH_W-1:0]     width,
    input  logic [2:0]                       fill,
    input  logic [7:0]                       pending,
    input  logic                             finish,
    input  logic                             reject,
    output mfbp_pkg::align_t                 result
);

    logic [mfbp_pkg::WIDTH_W-1:0]     lshift;
    logic [mfbp_pkg::FIELD_MAX_W-1:0] aligned;
    logic [mfbp_pkg::WORD_W-1:0]      placed;
    logic [mfbp_pkg::WIDTH_W-1:0]     tot;
    logic [mfbp_pkg::CNT_W-1:0]       nbytes;
    logic                             tail;

    always_comb
    begin
        lshift  = mfbp_pkg::WIDTH_W'(mfbp_pkg::FIELD_MAX_W) - width;
        aligned = value << lshift;
        placed  = {aligned, 8'h00} >> fill;
        tot     = {4'b0000, fill} + width;
        tail    = finish && (tot[2:0] != 3'd0);
        nbytes  = tot[6:3] + {3'b000, tail};

        result.word = {pending, 64'h0} | placed;
        if (reject)
        begin
            result.nbytes = '0;
            result.nres   = mfbp_pkg::CNT_W'(1);
        end
        else
        begin
            result.nbytes = nbytes;
            result.nres   = (nbytes == '0) ? mfbp_pkg::CNT_W'(1) : nbytes;
        end
    end

endmodule

>>> rtl/core/msb_first_bit_packer.sv
// MSB-first bit packer. Each input transaction appends the low field-width bits of a 64-bit
// value, most significant first, to the current message and streams out every byte that
// completes, one output transaction per byte, or one empty transaction if none completes.
// An item that would take the message past min(capacity, MAX_MSG_BYTES) bytes, or whose field
// width exceeds 64, is rejected with status 1 and changes nothing. tlast on the input closes the
// message, flushing the zero-padded partial byte. An item gives n results (one to nine): it is
// accepted in ST_IDLE, aligned in ST_LOAD, then emitted in ST_EMIT at one output transaction
// per cycle through the output register while m_tready allows. The input is not ready
// while an item is being emitted. Depends on mfbp_pkg, mfbp_align and the macros header.
`include "msb_first_bit_packer_macros.svh"

module msb_first_bit_packer
#(
    parameter int MAX_MSG_BYTES = 65535
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: field_value[63:0], field_width[70:64], zero pad[71].
    input  logic [mfbp_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: byte_valid[0], out_byte[8:1], end_of_message[9], status[10],
    // message_bits[29:11], zero pad[31:30].
    output logic [mfbp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mfbp_pkg::CAP_W-1:0]       cfg_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready
);

    localparam logic [19:0] MAX_LIMIT = 20'(MAX_MSG_BYTES);

    mfbp_pkg::state_t state_reg, state_next;

    logic [mfbp_pkg::CAP_W-1:0]       capacity_reg;
    logic [mfbp_pkg::BITS_W-1:0]      bit_total_reg, bit_total_next;
    logic [7:0]                       pending_reg, pending_next;
    logic [mfbp_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                             m_tvalid_reg, m_tvalid_next;

    logic [mfbp_pkg::FIELD_MAX_W-1:0] value_reg;
    logic [mfbp_pkg::WIDTH_W-1:0]     width_reg;
    logic                             finish_reg;
    logic                             reject_reg;
    logic [mfbp_pkg::WORD_W-1:0]      word_reg, word_next;
    logic [mfbp_pkg::CNT_W-1:0]       nbytes_reg;
    logic [mfbp_pkg::CNT_W-1:0]       nres_reg;
    logic [mfbp_pkg::BITS_W-1:0]      msgbits_reg;
    logic [mfbp_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                             m_tlast_reg, m_tlast_next;

    logic                             in_take;
    logic [19:0]                      limit;
    logic [19:0]                      sum;
    logic                             reject_now;
    logic [mfbp_pkg::BITS_W-1:0]      appended;
    mfbp_pkg::align_t                 align_res;

    logic                             load_out;
    logic                             final_res;
    logic                             is_byte;
    logic [7:0]                       res_byte;
    logic                             res_eom;

    assign s_tready  = (state_reg == mfbp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    always_comb
    begin
        limit = ({4'h0, capacity_reg} < MAX_LIMIT) ? {4'h0, capacity_reg} : MAX_LIMIT;
        sum   = {1'b0, bit_total_reg} + 20'(s_tdata[70:64]) + 20'd7;
        reject_now = (s_tdata[70:64] > 7'(mfbp_pkg::FIELD_MAX_W))
                     || ({3'b000, sum[19:3]} > limit);
        appended = bit_total_reg + mfbp_pkg::BITS_W'(width_reg);
    end

    mfbp_align u_align
    (
        .value   (value_reg),
        .width   (width_reg),
        .fill    (bit_total_reg[2:0]),
        .pending (pending_reg),
        .finish  (finish_reg),
        .reject  (reject_reg),
        .result  (align_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfbp_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = mfbp_pkg::ST_LOAD;
                end
            end
            mfbp_pkg::ST_LOAD:
            begin
                state_next = mfbp_pkg::ST_EMIT;
            end
            mfbp_pkg::ST_EMIT:
            begin
                if (load_out && final_res)
                begin
                    state_next = mfbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_out  = (state_reg == mfbp_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
        final_res = (idx_reg == nres_reg - mfbp_pkg::CNT_W'(1));
        is_byte   = (idx_reg < nbytes_reg);
        res_byte  = is_byte ? word_reg[71:64] : 8'h00;
        res_eom   = finish_reg && !reject_reg && final_res;

        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        pending_next   = pending_reg;
        bit_total_next = bit_total_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (state_reg == mfbp_pkg::ST_LOAD)
        begin
            idx_next  = '0;
            word_next = align_res.word;
            if (!reject_reg)
            begin
                bit_total_next = finish_reg ? '0 : appended;
            end
        end

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = final_res;
            m_tdata_next  = {2'b00, msgbits_reg, reject_reg, res_eom, res_byte, is_byte};
            idx_next      = idx_reg + mfbp_pkg::CNT_W'(1);
            if (is_byte)
            begin
                word_next = {word_reg[63:0], 8'h00};
            end
            if (final_res && !reject_reg)
            begin
                if (finish_reg)
                begin
                    pending_next = 8'h00;
                end
                else
                begin
                    pending_next = is_byte ? word_reg[63:56] : word_reg[71:64];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfbp_pkg::ST_IDLE;
            capacity_reg  <= 16'hFFFF;
            bit_total_reg <= '0;
            pending_reg   <= 8'h00;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_total_reg <= bit_total_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (in_take)
        begin
            value_reg  <= s_tdata[63:0];
            width_reg  <= s_tdata[70:64];
            finish_reg <= s_tlast;
            reject_reg <= reject_now;
        end
        if (state_reg == mfbp_pkg::ST_LOAD)
        begin
            nbytes_reg  <= align_res.nbytes;
            nres_reg    <= align_res.nres;
            msgbits_reg <= reject_reg ? bit_total_reg : appended;
        end
    end

    `MFBP_ASSERT_NXT(a_take_loads, clk, rst_n, in_take, state_reg == mfbp_pkg::ST_LOAD)
    `MFBP_ASSERT_IMP(a_idx_bound, clk, rst_n, state_reg == mfbp_pkg::ST_EMIT, idx_reg < nres_reg)
    `MFBP_ASSERT_NXT(a_reject_keeps, clk, rst_n, state_reg == mfbp_pkg::ST_LOAD && reject_reg, $stable(bit_total_reg))
    `MFBP_ASSERT_NXT(a_final_tlast, clk, rst_n, load_out && final_res, m_tvalid && m_tlast && state_reg == mfbp_pkg::ST_IDLE)

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the MSB-first bit packer: a queue-fed driver, a monitor that
// predicts every output byte transaction and checks it, and a capacity register sequence.
// Depends on mfbp_pkg and the msb_first_bit_packer RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned MSG_LIMIT   = 65535;
    localparam int          HOLD_CYCLES = 300;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          IDLE_PCT    = 13;

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  width;
        logic        finish;
    } field_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        eom;
        logic        status;
        logic [18:0] msg_bits;
        logic        last;
    } byte_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic [mfbp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mfbp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mfbp_pkg::CAP_W-1:0]      cfg_data = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;

    field_item_t  field_q[$];
    byte_result_t result_q[$];
    field_item_t  drv_item;

    logic [15:0] cap_bytes = 16'hffff;
    logic [7:0]  pend_byte = '0;
    logic [19:0] msg_total = '0;

    int  n_queued = 0;
    int  n_accepted = 0;
    int  err_count = 0;
    int  idle_cycles = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;
    bit  s_acc = 1'b0;

    msb_first_bit_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic append_field(input field_item_t it);
        byte_result_t res[10];
        byte_result_t r;
        int unsigned  limit;
        int unsigned  needed;
        int unsigned  fill;
        int unsigned  n;
        int unsigned  i;
        logic [7:0]   acc;
        limit = (cap_bytes < MSG_LIMIT) ? cap_bytes : MSG_LIMIT;
        needed = (msg_total + it.width + 7) / 8;
        if (it.width > 64 || needed > limit)
        begin
            r = '0;
            r.status = 1'b1;
            r.msg_bits = msg_total[18:0];
            r.last = 1'b1;
            result_q.push_back(r);
            return;
        end
        acc = pend_byte;
        fill = msg_total[2:0];
        n = 0;
        for (i = it.width; i > 0; i--)
        begin
            if (it.value[i-1])
                acc[7-fill] = 1'b1;
            fill++;
            if (fill == 8)
            begin
                res[n] = '0;
                res[n].byte_valid = 1'b1;
                res[n].out_byte = acc;
                n++;
                acc = '0;
                fill = 0;
            end
        end
        msg_total = msg_total + it.width;
        pend_byte = acc;
        if (it.finish)
        begin
            if (fill > 0)
            begin
                res[n] = '0;
                res[n].byte_valid = 1'b1;
                res[n].out_byte = acc;
                res[n].eom = 1'b1;
                n++;
            end
            else if (n > 0)
                res[n-1].eom = 1'b1;
            else
            begin
                res[0] = '0;
                res[0].eom = 1'b1;
                n = 1;
            end
        end
        else if (n == 0)
        begin
            res[0] = '0;
            n = 1;
        end
        res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
        begin
            res[i].msg_bits = msg_total[18:0];
            result_q.push_back(res[i]);
        end
        if (it.finish)
        begin
            pend_byte = '0;
            msg_total = '0;
        end
    endtask

    task automatic check_result();
        byte_result_t got;
        byte_result_t want;
        got.byte_valid = m_tdata[0];
        got.out_byte = m_tdata[8:1];
        got.eom = m_tdata[9];
        got.status = m_tdata[10];
        got.msg_bits = m_tdata[29:11];
        got.last = m_tlast;
        if (result_q.size() == 0)
        begin
            report_mismatch("output transaction with nothing expected", m_tdata, 0);
            return;
        end
        want = result_q.pop_front();
        if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.eom !== want.eom)
            report_mismatch("end_of_message", got.eom, want.eom);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.msg_bits !== want.msg_bits)
            report_mismatch("message_bits", got.msg_bits, want.msg_bits);
        if (got.last !== want.last)
            report_mismatch("tlast", got.last, want.last);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_acc)
        begin
            if (field_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                drv_item = field_q.pop_front();
                s_tdata <= {1'b0, drv_item.width, drv_item.value};
                s_tlast <= drv_item.finish;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_acc = s_tvalid && s_tready;
            if (s_acc)
            begin
                append_field('{s_tdata[63:0], s_tdata[70:64], s_tlast});
                n_accepted++;
            end
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[msb_first_bit_packer] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_field(input logic [63:0] value, input logic [6:0] width,
                               input logic finish);
        field_q.push_back('{value, width, finish});
        n_queued++;
    endtask

    function automatic field_item_t random_field();
        field_item_t it;
        int unsigned pick;
        pick = $urandom_range(99);
        it.value = {$urandom, $urandom};
        if (pick < 3)
            it.width = 7'($urandom_range(127, 65));
        else if (pick < 23)
            it.width = 7'd64;
        else if (pick < 45)
            it.width = 7'($urandom_range(8, 0));
        else
            it.width = 7'($urandom_range(64, 0));
        it.finish = ($urandom_range(9) == 0);
        return it;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
        begin
            field_q.push_back(random_field());
            n_queued++;
        end
    endtask

    task automatic wait_drained();
        while (n_queued != n_accepted || result_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_bytes = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_capacity(16'hffff);
        queue_field(64'h0, 7'd0, 1'b0);
        queue_field(64'h0, 7'd0, 1'b1);
        queue_field(64'hffff_ffff_ffff_ffff, 7'd64, 1'b0);
        queue_field(64'h0, 7'd64, 1'b1);
        queue_field(64'h1, 7'd1, 1'b0);
        queue_field(64'h55, 7'd7, 1'b0);
        queue_field(64'h5, 7'd3, 1'b1);
        queue_field(64'h7f, 7'd7, 1'b0);
        queue_field(64'ha5a5_5a5a_c3c3_3c3c, 7'd64, 1'b1);
        queue_field(64'h8000_0000_0000_0001, 7'd65, 1'b0);
        queue_field(64'hffff_ffff_ffff_ffff, 7'd127, 1'b1);
        queue_field(64'hffff_ffff_ffff_fff3, 7'd4, 1'b1);
        queue_field(64'h81, 7'd8, 1'b1);
        wait_drained();

        set_capacity(16'h0000);
        queue_field(64'hffff_ffff_ffff_ffff, 7'd0, 1'b0);
        queue_field(64'h1, 7'd1, 1'b0);
        queue_field(64'h0, 7'd0, 1'b1);
        queue_field(64'hffff_ffff_ffff_ffff, 7'd64, 1'b1);
        wait_drained();

        set_capacity(16'h0001);
        queue_field(64'h3c, 7'd8, 1'b0);
        queue_field(64'h1, 7'd1, 1'b0);
        queue_field(64'h0, 7'd0, 1'b1);
        queue_field(64'h6, 7'd3, 1'b0);
        queue_field(64'h1b, 7'd5, 1'b0);
        queue_field(64'h1, 7'd1, 1'b1);
        queue_field(64'h0, 7'd0, 1'b1);
        wait_drained();

        // The sink holds off while the source keeps offering, so the packer backs up.
        set_capacity(16'hffff);
        hold_req++;
        queue_random(120);
        wait_drained();

        set_capacity(16'($urandom_range(40, 2)));
        queue_random(100);
        wait_drained();

        set_capacity(16'($urandom_range(2000, 41)));
        calm = 1'b1;
        queue_random(90);
        wait_drained();
        calm = 1'b0;

        repeat (24) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch("expected results left over", result_q.size(), 0);
        if (err_count == 0)
            $display("[msb_first_bit_packer] OK");
        else
            $display("[msb_first_bit_packer] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/mfbp_pkg.sv
rtl/core/mfbp_align.sv
rtl/core/msb_first_bit_packer.sv
sim/testbench.sv
